FILE: rtl/core/dssa_pkg.sv
// ----------------------------------------------------------------------------
// dssa_pkg
// Types and constants for two stacks that share one word memory.
// ----------------------------------------------------------------------------
`default_nettype none

package dssa_pkg;

   // memory geometry
   localparam int DEPTH      = 256;
   localparam int WORD_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = ADDR_W + 1;

   // capacity register limits
   localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(2);
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

   // request operations
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_SEARCH = 3'd4
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_UNSUP    = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEARCH
   } state_type;

   // sides
   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   // request payload
   typedef struct packed {
      logic [2:0]                   req_type;
      logic                         side;
      logic signed [WORD_WIDTH-1:0] value;
   } req_type;

   // response payload
   typedef struct packed {
      logic [2:0]                   status;
      logic signed [WORD_WIDTH-1:0] data;
      logic [ADDR_W-1:0]            found_index;
      logic [CNT_W-1:0]             side_size;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/dual_stack_shared_array.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// Two stacks in one synchronous word memory: the left stack grows up from
// index 0, the right one down from capacity-1. Push, pop, peek, clear and a
// linear search of the left stack.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+-----------------------
//   req_     | in        | valid / stall  | dssa_pkg::req_type
//   rsp_     | out       | valid / stall  | dssa_pkg::rsp_type
//   csr_     | in        | valid / ready  | capacity, 9 bits
//
// Push, clear and rejected requests are answered from the idle state; pop
// and peek go through the read state to wait for the registered read data.
// A search issues one memory read per cycle from index 0 up the left stack
// until it finds a match or reads the top entry. One request is in flight at a time.
// Reset clears both stacks and sets capacity to 256; memory words are kept.
// A stalled response holds in the output register; a new request is taken
// in the cycle that register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_shared_array (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire dssa_pkg::req_type                      req_data,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output dssa_pkg::rsp_type                           rsp_data,
   // capacity register write
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [dssa_pkg::CNT_W-1:0]             csr_data
);

   localparam int AW = dssa_pkg::ADDR_W;
   localparam int CW = dssa_pkg::CNT_W;
   localparam int WW = dssa_pkg::WORD_WIDTH;

   // shared word memory
   logic [WW-1:0] mem [dssa_pkg::DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [WW-1:0] rd_data_ff;

   // control state
   dssa_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       capacity_ff, capacity_in;
   logic [CW-1:0]       left_cnt_ff, left_cnt_in;
   logic [CW-1:0]       right_cnt_ff, right_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload state
   dssa_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                op_side_ff, op_side_in;
   logic [WW-1:0]       key_ff, key_in;
   logic [AW-1:0]       srch_idx_ff, srch_idx_in;

   // helpers
   logic          out_free;
   logic          req_accept;
   logic          full;
   logic [CW:0]   used;
   logic          immediate;
   logic [2:0]    imm_status;
   logic          srch_hit;
   logic          srch_last;
   logic [CW-1:0] right_push_addr;
   logic [CW-1:0] right_top_addr;
   logic [CW-1:0] left_top_addr;

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == dssa_pkg::S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == dssa_pkg::S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // pointer arithmetic
   assign used            = {1'b0, left_cnt_ff} + {1'b0, right_cnt_ff};
   assign full            = (used >= {1'b0, capacity_ff});
   assign right_push_addr = capacity_ff - right_cnt_ff - CW'(1);
   assign right_top_addr  = capacity_ff - right_cnt_ff;
   assign left_top_addr   = left_cnt_ff - CW'(1);

   // search compare stage
   assign srch_hit  = (rd_data_ff == key_ff);
   assign srch_last = ({1'b0, srch_idx_ff} + CW'(1)) == left_cnt_ff;

   // sequencer: next state, counters, memory controls and response
   always_comb begin
      state_in     = state_ff;
      capacity_in  = capacity_ff;
      left_cnt_in  = left_cnt_ff;
      right_cnt_in = right_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      op_side_in   = op_side_ff;
      key_in       = key_ff;
      srch_idx_in  = srch_idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      immediate    = 1'b0;
      imm_status   = dssa_pkg::STAT_OK;

      unique case (state_ff)
         dssa_pkg::S_IDLE: begin
            if (req_accept) begin
               op_side_in = req_data.side;
               immediate  = 1'b1;
               unique case (req_data.req_type) inside
                  dssa_pkg::OP_PUSH: begin
                     if (full) begin
                        imm_status = dssa_pkg::STAT_FULL;
                     end else if (req_data.side == dssa_pkg::SIDE_LEFT) begin
                        mem_we      = 1'b1;
                        mem_waddr   = left_cnt_ff[AW-1:0];
                        mem_wdata   = req_data.value;
                        left_cnt_in = left_cnt_ff + CW'(1);
                     end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = right_push_addr[AW-1:0];
                        mem_wdata    = req_data.value;
                        right_cnt_in = right_cnt_ff + CW'(1);
                     end
                  end
                  dssa_pkg::OP_POP, dssa_pkg::OP_PEEK: begin
                     if (req_data.side == dssa_pkg::SIDE_LEFT) begin
                        if (left_cnt_ff == '0) begin
                           imm_status = dssa_pkg::STAT_EMPTY;
                        end else begin
                           immediate = 1'b0;
                           mem_re    = 1'b1;
                           mem_raddr = left_top_addr[AW-1:0];
                           state_in  = dssa_pkg::S_READ;
                           if (req_data.req_type == dssa_pkg::OP_POP) begin
                              left_cnt_in = left_cnt_ff - CW'(1);
                           end
                        end
                     end else begin
                        if (right_cnt_ff == '0) begin
                           imm_status = dssa_pkg::STAT_EMPTY;
                        end else begin
                           immediate = 1'b0;
                           mem_re    = 1'b1;
                           mem_raddr = right_top_addr[AW-1:0];
                           state_in  = dssa_pkg::S_READ;
                           if (req_data.req_type == dssa_pkg::OP_POP) begin
                              right_cnt_in = right_cnt_ff - CW'(1);
                           end
                        end
                     end
                  end
                  dssa_pkg::OP_CLEAR: begin
                     if (req_data.side == dssa_pkg::SIDE_LEFT) begin
                        left_cnt_in = '0;
                     end else begin
                        right_cnt_in = '0;
                     end
                  end
                  dssa_pkg::OP_SEARCH: begin
                     if (req_data.side == dssa_pkg::SIDE_RIGHT) begin
                        imm_status = dssa_pkg::STAT_UNSUP;
                     end else if (left_cnt_ff == '0) begin
                        imm_status = dssa_pkg::STAT_NOTFOUND;
                     end else begin
                        immediate   = 1'b0;
                        mem_re      = 1'b1;
                        mem_raddr   = '0;
                        key_in      = req_data.value;
                        srch_idx_in = '0;
                        state_in    = dssa_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                     imm_status = dssa_pkg::STAT_UNSUP;
                  end
               endcase

               // requests with no memory read to wait for answer straight away
               if (immediate) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = imm_status;
                  rsp_data_in.data        = '0;
                  rsp_data_in.found_index = '0;
                  rsp_data_in.side_size   = (req_data.side == dssa_pkg::SIDE_RIGHT) ?
                                            right_cnt_in : left_cnt_in;
               end
            end
         end

         dssa_pkg::S_READ: begin
            // read data is held until the output register is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = dssa_pkg::STAT_OK;
               rsp_data_in.data        = rd_data_ff;
               rsp_data_in.found_index = '0;
               rsp_data_in.side_size   = (op_side_ff == dssa_pkg::SIDE_RIGHT) ?
                                         right_cnt_ff : left_cnt_ff;
               state_in                = dssa_pkg::S_IDLE;
            end
         end

         dssa_pkg::S_SEARCH: begin
            if (srch_hit || srch_last) begin
               if (out_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = srch_hit ? dssa_pkg::STAT_OK
                                                     : dssa_pkg::STAT_NOTFOUND;
                  rsp_data_in.data        = '0;
                  rsp_data_in.found_index = srch_hit ? srch_idx_ff : '0;
                  rsp_data_in.side_size   = left_cnt_ff;
                  state_in                = dssa_pkg::S_IDLE;
               end
            end else begin
               // fetch the next entry up the left stack
               mem_re      = 1'b1;
               mem_raddr   = srch_idx_ff + AW'(1);
               srch_idx_in = srch_idx_ff + AW'(1);
            end
         end

         default: begin
            state_in = dssa_pkg::S_IDLE;
         end
      endcase

      // capacity write empties both stacks, clamped into range
      if (csr_valid && csr_ready) begin
         if (csr_data < dssa_pkg::CAP_MIN) begin
            capacity_in = dssa_pkg::CAP_MIN;
         end else if (csr_data > dssa_pkg::CAP_MAX) begin
            capacity_in = dssa_pkg::CAP_MAX;
         end else begin
            capacity_in = csr_data;
         end
         left_cnt_in  = '0;
         right_cnt_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dssa_pkg::S_IDLE;
         capacity_ff  <= dssa_pkg::CAP_MAX;
         left_cnt_ff  <= '0;
         right_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         left_cnt_ff  <= left_cnt_in;
         right_cnt_ff <= right_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_side_ff  <= op_side_in;
      key_ff      <= key_in;
      srch_idx_ff <= srch_idx_in;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // memory read port, registered data
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

`default_nettype wire
